[rtl/point_box_distance_top_defines.svh]
// Assertion macros used by the point_box_distance top module.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef POINT_BOX_DISTANCE_TOP_DEFINES_SVH
`define POINT_BOX_DISTANCE_TOP_DEFINES_SVH

// same-cycle implication
`define PBD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pbd_pkg.sv]
// Package for point_box_distance: register indexes and fixed widths.
// No dependencies.
package pbd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int DIST_W     = 17;
	localparam int SQRT_IN_W  = 2 * DIST_W;
	localparam int SQRT_REM_W = DIST_W + 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_X  = 3'd0,
		REG_HIGH_X = 3'd1,
		REG_LOW_Y  = 3'd2,
		REG_HIGH_Y = 3'd3,
		REG_LOW_Z  = 3'd4,
		REG_HIGH_Z = 3'd5
	} pbd_reg_t;

	localparam int NUM_REGS = 6;

endpackage

[rtl/point_box_distance_top.sv]
// Point versus axis-aligned box query: one point transaction in, one result out, every cycle
// when nothing stalls. A point passes the front register, the queue, the square and sum stages,
// then a 17-stage square-root pipeline, one result bit per stage; throughput is one
// transaction per cycle while result_ready holds. The front end and the four-entry
// queue keep taking points while the result side is stalled. Box registers are written
// through cfg_we/cfg_index/cfg_data (indexes 0..5: low x, high x, low y, high y, low z,
// high z; other indexes are ignored) and should only change while no query is in flight.
// Depends on pbd_pkg, pbd_front, pbd_fifo, pbd_back and the defines header.
`include "point_box_distance_top_defines.svh"

module point_box_distance_top #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]         cfg_data,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  logic [COORD_BITS-1:0]         point_x,
	input  logic [COORD_BITS-1:0]         point_y,
	input  logic [COORD_BITS-1:0]         point_z,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          is_inside,
	output logic [pbd_pkg::DIST_W-1:0]    outside_distance,
	output logic [pbd_pkg::DIST_W-1:0]    inside_distance
);

	localparam int ENTRY_W = 3 * COORD_BITS + 3;

	logic                    fr_valid;
	logic                    fr_ready;
	logic [3*COORD_BITS-1:0] fr_near;
	logic [2:0]              fr_within;
	logic                    bk_valid;
	logic                    bk_ready;
	logic [ENTRY_W-1:0]      bk_entry;

	pbd_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.item_valid  (fr_valid),
		.item_ready  (fr_ready),
		.item_near   (fr_near),
		.item_within (fr_within)
	);

	pbd_fifo #(
		.WIDTH (ENTRY_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  ({fr_within, fr_near}),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_entry)
	);

	pbd_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (bk_valid),
		.item_ready       (bk_ready),
		.item_near        (bk_entry[3*COORD_BITS-1:0]),
		.item_within      (bk_entry[ENTRY_W-1 -: 3]),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.is_inside        (is_inside),
		.outside_distance (outside_distance),
		.inside_distance  (inside_distance)
	);

	`PBD_ASSERT_IMPLIES(a_stall_from_queue, !point_ready, fr_valid && !fr_ready, "bad stall")
	`PBD_ASSERT_NEXT(a_accept_held, point_valid && point_ready, fr_valid, "point lost")
	`PBD_ASSERT_IMPLIES(a_inside_zero, result_valid && is_inside, ~|outside_distance, "not zero")
	`PBD_ASSERT_IMPLIES(a_dist_order, result_valid, outside_distance <= inside_distance, "bad order")

endmodule

[rtl/pbd_front.sv]
// Front end: box registers, per-axis nearest-face distance and bounds check.
// Depends on pbd_pkg.
module pbd_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]         cfg_data,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  logic [COORD_BITS-1:0]         point_x,
	input  logic [COORD_BITS-1:0]         point_y,
	input  logic [COORD_BITS-1:0]         point_z,
	output logic                          item_valid,
	input  logic                          item_ready,
	output logic [3*COORD_BITS-1:0]       item_near,
	output logic [2:0]                    item_within
);

	localparam int CB = COORD_BITS;

	logic signed [CB-1:0]   box_q [pbd_pkg::NUM_REGS];
	logic signed [CB-1:0]   pt [3];
	logic [CB-1:0]          near_c [3];
	logic [2:0]             within_c;
	logic                   valid_s1;
	logic [3*CB-1:0]        near_s1;
	logic [2:0]             within_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pbd_pkg::NUM_REGS; i++) box_q[i] <= '0;
		end else if (cfg_we && (cfg_index <= pbd_pkg::REG_HIGH_Z)) begin
			box_q[cfg_index] <= cfg_data;
		end
	end

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic signed [CB-1:0] lo;
		logic signed [CB-1:0] hi;
		logic signed [CB:0]   dl_w;
		logic signed [CB:0]   dh_w;
		logic signed [CB:0]   dl_n;
		logic signed [CB:0]   dh_n;
		logic [CB-1:0]        dl;
		logic [CB-1:0]        dh;

		assign lo   = box_q[2*a];
		assign hi   = box_q[2*a+1];
		assign dl_w = {pt[a][CB-1], pt[a]} - {lo[CB-1], lo};
		assign dh_w = {pt[a][CB-1], pt[a]} - {hi[CB-1], hi};
		assign dl_n = -dl_w;
		assign dh_n = -dh_w;
		assign dl   = dl_w[CB] ? dl_n[CB-1:0] : dl_w[CB-1:0];
		assign dh   = dh_w[CB] ? dh_n[CB-1:0] : dh_w[CB-1:0];
		assign near_c[a]   = (dl < dh) ? dl : dh;
		assign within_c[a] = (pt[a] >= lo) && (pt[a] <= hi);
	end

	assign point_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point_ready) begin
			valid_s1 <= point_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (point_valid && point_ready) begin
			near_s1   <= {near_c[2], near_c[1], near_c[0]};
			within_s1 <= within_c;
		end
	end

	assign item_valid  = valid_s1;
	assign item_near   = near_s1;
	assign item_within = within_s1;

endmodule

[rtl/pbd_fifo.sv]
// Small transaction queue between front and back ends.
// Depends on pbd_pkg.
module pbd_fifo #(
	parameter int WIDTH = 51
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0]                  mem_q [pbd_pkg::FIFO_DEPTH];
	logic [pbd_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [pbd_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [pbd_pkg::FIFO_CNT_W-1:0]    count_q;
	logic                              push;
	logic                              pop;

	assign push_ready = (count_q != pbd_pkg::FIFO_CNT_W'(pbd_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

[rtl/pbd_isqrt.sv]
// Pipelined floor square root, one result bit per stage, saturating output.
// Depends on pbd_pkg.
module pbd_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          sat_in,
	input  logic [pbd_pkg::SQRT_IN_W-1:0] value_in,
	output logic [pbd_pkg::DIST_W-1:0]    root_out
);

	localparam int STAGES = pbd_pkg::DIST_W;
	localparam int IN_W   = pbd_pkg::SQRT_IN_W;
	localparam int REM_W  = pbd_pkg::SQRT_REM_W;

	logic [REM_W-1:0]  rem_q  [STAGES];
	logic [STAGES-1:0] root_q [STAGES];
	logic [IN_W-1:0]   val_q  [STAGES];
	logic              sat_q  [STAGES];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [REM_W-1:0]  rem_prev;
		logic [STAGES-1:0] root_prev;
		logic [IN_W-1:0]   val_prev;
		logic              sat_prev;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;
		logic [STAGES-1:0] root_nxt;

		if (g == 0) begin : g_first
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign val_prev  = value_in;
			assign sat_prev  = sat_in;
		end else begin : g_next
			assign rem_prev  = rem_q[g-1];
			assign root_prev = root_q[g-1];
			assign val_prev  = val_q[g-1];
			assign sat_prev  = sat_q[g-1];
		end

		assign rem_sh   = {rem_prev[REM_W-3:0], val_prev[IN_W-1 -: 2]};
		assign trial    = REM_W'({root_prev, 2'b01});
		assign ge       = (rem_sh >= trial);
		assign root_nxt = {root_prev[STAGES-2:0], ge};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g]  <= ge ? (rem_sh - trial) : rem_sh;
				val_q[g]  <= {val_prev[IN_W-3:0], 2'b00};
				sat_q[g]  <= sat_prev;
				root_q[g] <= ((g == STAGES - 1) && sat_prev) ? '1 : root_nxt;
			end
		end
	end

	assign root_out = root_q[STAGES-1];

endmodule

[rtl/pbd_back.sv]
// Back end: squares, sums and square roots; ends in the result register.
// Depends on pbd_pkg and pbd_isqrt.
module pbd_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [3*COORD_BITS-1:0]     item_near,
	input  logic [2:0]                  item_within,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        is_inside,
	output logic [pbd_pkg::DIST_W-1:0]  outside_distance,
	output logic [pbd_pkg::DIST_W-1:0]  inside_distance
);

	localparam int CB     = COORD_BITS;
	localparam int SQ_W   = 2 * CB;
	localparam int SUM_W  = 2 * CB + 2;
	localparam int IN_W   = pbd_pkg::SQRT_IN_W;
	localparam int EXT_W  = (SUM_W > IN_W) ? SUM_W : IN_W + 1;
	localparam int STAGES = pbd_pkg::DIST_W;

	logic               en;
	logic               valid_s1;
	logic [SQ_W-1:0]    sq_s1 [3];
	logic [2:0]         within_s1;
	logic [SUM_W-1:0]   sum_out_c;
	logic [SUM_W-1:0]   sum_in_c;
	logic [EXT_W-1:0]   out_ext;
	logic [EXT_W-1:0]   in_ext;
	logic               valid_s2;
	logic               inside_s2;
	logic [IN_W-1:0]    out_s2;
	logic [IN_W-1:0]    in_s2;
	logic               sat_out_s2;
	logic               sat_in_s2;
	logic [STAGES-1:0]  vld_q;
	logic [STAGES-1:0]  inside_q;

	assign en         = !vld_q[STAGES-1] || result_ready;
	assign item_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			vld_q    <= '0;
		end else if (en) begin
			valid_s1 <= item_valid;
			valid_s2 <= valid_s1;
			vld_q    <= {vld_q[STAGES-2:0], valid_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				sq_s1[a] <= SQ_W'(item_near[a*CB +: CB]) * SQ_W'(item_near[a*CB +: CB]);
			end
			within_s1 <= item_within;
		end
	end

	assign sum_in_c  = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
	assign sum_out_c = (within_s1[0] ? '0 : SUM_W'(sq_s1[0]))
	                 + (within_s1[1] ? '0 : SUM_W'(sq_s1[1]))
	                 + (within_s1[2] ? '0 : SUM_W'(sq_s1[2]));
	assign out_ext   = EXT_W'(sum_out_c);
	assign in_ext    = EXT_W'(sum_in_c);

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s2  <= &within_s1;
			out_s2     <= out_ext[IN_W-1:0];
			in_s2      <= in_ext[IN_W-1:0];
			sat_out_s2 <= |out_ext[EXT_W-1:IN_W];
			sat_in_s2  <= |in_ext[EXT_W-1:IN_W];
			inside_q   <= {inside_q[STAGES-2:0], inside_s2};
		end
	end

	pbd_isqrt u_sqrt_out (
		.clk      (clk),
		.en       (en),
		.sat_in   (sat_out_s2),
		.value_in (out_s2),
		.root_out (outside_distance)
	);

	pbd_isqrt u_sqrt_in (
		.clk      (clk),
		.en       (en),
		.sat_in   (sat_in_s2),
		.value_in (in_s2),
		.root_out (inside_distance)
	);

	assign result_valid = vld_q[STAGES-1];
	assign is_inside    = inside_q[STAGES-1];

endmodule
